>>> hw/rtl/gpg_pkg.sv
// ----------------------------------------------------------------------------
// GPIO pattern generator package
// Shared constants, register indexes, mode codes and the types that pass
// between the sequencer and the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package gpg_pkg;

   localparam int PAT_LEN_LIMIT = 32;

   localparam int TIME_W     = 64;
   localparam int PHASE_W    = 32;
   localparam int MODE_W     = 2;
   localparam int LEN_W      = 6;
   localparam int IDX_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W      = $clog2(PHASE_W);

   // Longest usable pattern: the smaller of the word width and PAT_LEN_LIMIT.
   localparam int MAX_LEN = (PAT_LEN_LIMIT < PHASE_W) ? PAT_LEN_LIMIT : PHASE_W;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ON_TIME      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_WORD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_USE_CONTROL  = 3'd7;

   // Pattern modes.
   localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BLINK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PWM    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd3;

   // Request from the sequencer to the divider.
   typedef struct packed {
      logic               start;
      logic [PHASE_W-1:0] dividend;
   } gpg_div_req_type;

   // Result of the divider: remainder and the quotient reduced modulo the
   // pattern length, valid in the cycle that done is high.
   typedef struct packed {
      logic               done;
      logic [PHASE_W-1:0] remainder;
      logic [IDX_W-1:0]   wrap_mod;
   } gpg_div_rsp_type;

   // Pattern length in use, clamped to the longest usable pattern.
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] lim;
      lim = LEN_W'(MAX_LEN);
      eff_len = (len > lim) ? lim : len;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gpg_ifs.sv
// ----------------------------------------------------------------------------
// GPIO pattern generator channel interfaces
// Valid/ready channels for the tick words and the pin result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpg_req_if;
   import gpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_us;
   logic              control_present;
   logic              control_nonzero;

   modport source (output valid, now_us, control_present, control_nonzero, input ready);
   modport sink   (input valid, now_us, control_present, control_nonzero, output ready);
endinterface

interface gpg_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic pin_write;

   modport source (output valid, pin_level, pin_write, input ready);
   modport sink   (input valid, pin_level, pin_write, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gpio_pattern_generator.sv
// ----------------------------------------------------------------------------
// GPIO pattern generator
// Drives one pin level from timestamped ticks: static, blink, PWM or a
// custom bit pattern, with inversion, enable and external control gating.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Word contents
//   req_chan  in         valid / ready    now_us, control_present, control_nonzero
//   rsp_chan  out        valid / ready    pin_level, pin_write
//   csr_*     in         csr_we only      csr_index, csr_wdata
//
// A tick that is disabled, skipped or forced off by the control signal is
// answered directly: its result word appears in the next cycle and the next
// tick can be taken at the following edge. A timed tick that needs no
// division (the first one, or any tick with a zero period) goes straight to
// the final step. A later timed tick with a non-zero period passes through
// the divide state: the 32-bit phase is reduced modulo the period by a
// restoring divider that resolves one quotient bit a cycle, and no new tick
// is taken until the final step has written its result word.
// Reset is synchronous and active high; it clears the sequencer, the started
// flag, pattern index, pin level and result valid flag, and loads reset values.
// The result word is held in an output register, so a stalled consumer only
// blocks the next tick once that word is still waiting at the end of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_pattern_generator (
   input  logic                               clock,
   input  logic                               reset,
   gpg_req_if.sink                            req_chan,
   gpg_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [gpg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gpg_pkg::*;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [MODE_W-1:0]  mode_ff;
   logic [PHASE_W-1:0] period_ff;
   logic [PHASE_W-1:0] on_time_ff;
   logic [PHASE_W-1:0] pat_word_ff;
   logic [LEN_W-1:0]   pat_len_ff;
   logic               enable_ff;
   logic               invert_ff;
   logic               use_ctl_ff;

   // Timing state. Only the low half of the last time stamp matters, since
   // the elapsed time is truncated to 32 bits before it enters the phase.
   logic               started_ff, started_in;
   logic [PHASE_W-1:0] last_ff,    last_in;
   logic [PHASE_W-1:0] phase_ff,   phase_in;
   logic [IDX_W-1:0]   idx_ff,     idx_in;
   logic               level_ff,   level_in;
   logic               first_ff,   first_in;
   logic               wrap_ff,    wrap_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_level_ff, rsp_level_in;
   logic               rsp_write_ff, rsp_write_in;

   gpg_div_req_type    div_req;
   gpg_div_rsp_type    div_rsp;

   logic               req_accept;
   logic               force_off;
   logic               skip_tick;
   logic [PHASE_W-1:0] phase_sum;
   logic [LEN_W-1:0]   n_len;
   logic [LEN_W-1:0]   idx_add;
   logic [IDX_W-1:0]   idx_new;
   logic               want;

   assign n_len = eff_len(pat_len_ff);

   // A new tick may enter only from idle and only when the output register
   // is free or is being emptied in this cycle.
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign force_off = !enable_ff || (use_ctl_ff && req_chan.control_present &&
                                     !req_chan.control_nonzero);
   assign skip_tick = enable_ff && use_ctl_ff && !req_chan.control_present;

   assign phase_sum = phase_ff + req_chan.now_us[PHASE_W-1:0] - last_ff;

   assign div_req.start    = req_accept && !force_off && !skip_tick && started_ff &&
                             (period_ff != '0);
   assign div_req.dividend = phase_sum;

   gpg_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .divisor  (period_ff),
      .pat_len  (n_len),
      .div_rsp  (div_rsp)
   );

   // Final step: advance the custom pattern index by the number of period
   // wraps and work out the pattern level for the reduced phase.
   always_comb begin
      idx_add = {1'b0, idx_ff} + {1'b0, div_rsp.wrap_mod};
      idx_new = idx_ff;
      if (wrap_ff && (mode_ff == MODE_CUSTOM) && (n_len != '0)) begin
         idx_new = (idx_add >= n_len) ? IDX_W'(idx_add - n_len) : idx_add[IDX_W-1:0];
      end

      case (mode_ff) inside
         MODE_STATIC:         want = 1'b1;
         MODE_BLINK, MODE_PWM: want = (phase_ff < on_time_ff);
         default:             want = (n_len != '0) && pat_word_ff[idx_new];
      endcase
      want = want ^ invert_ff;
   end

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      first_in     = first_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_level_in = rsp_level_ff;
      rsp_write_in = rsp_write_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (force_off) begin
                  // Pin goes to its off level; time does not move on.
                  level_in     = invert_ff;
                  rsp_valid_in = 1'b1;
                  rsp_level_in = invert_ff;
                  rsp_write_in = (level_ff != invert_ff);
               end else if (skip_tick) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = level_ff;
                  rsp_write_in = 1'b0;
               end else if (!started_ff) begin
                  started_in = 1'b1;
                  last_in    = req_chan.now_us[PHASE_W-1:0];
                  phase_in   = '0;
                  first_in   = 1'b1;
                  wrap_in    = 1'b0;
                  state_in   = ST_FIN;
               end else begin
                  last_in  = req_chan.now_us[PHASE_W-1:0];
                  phase_in = phase_sum;
                  first_in = 1'b0;
                  wrap_in  = (period_ff != '0);
                  state_in = (period_ff != '0) ? ST_DIV : ST_FIN;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               phase_in = div_rsp.remainder;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            idx_in       = idx_new;
            level_in     = want;
            rsp_valid_in = 1'b1;
            rsp_level_in = want;
            rsp_write_in = first_ff || (want != level_ff);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Writing either pattern register restarts the pattern at bit zero.
      if (csr_we && ((csr_index == REG_PATTERN_WORD) || (csr_index == REG_PATTERN_LEN))) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      last_ff      <= last_in;
      first_ff     <= first_in;
      wrap_ff      <= wrap_in;
      rsp_level_ff <= rsp_level_in;
      rsp_write_ff <= rsp_write_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         idx_ff       <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         idx_ff       <= idx_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Config registers: user must write only while the block is idle, not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STATIC;
         period_ff   <= '0;
         on_time_ff  <= '0;
         pat_word_ff <= '0;
         pat_len_ff  <= '0;
         enable_ff   <= 1'b1;
         invert_ff   <= 1'b0;
         use_ctl_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MODE:         mode_ff     <= csr_wdata[MODE_W-1:0];
            REG_PERIOD:       period_ff   <= csr_wdata[PHASE_W-1:0];
            REG_ON_TIME:      on_time_ff  <= csr_wdata[PHASE_W-1:0];
            REG_PATTERN_WORD: pat_word_ff <= csr_wdata[PHASE_W-1:0];
            REG_PATTERN_LEN:  pat_len_ff  <= csr_wdata[LEN_W-1:0];
            REG_ENABLE:       enable_ff   <= csr_wdata[0];
            REG_INVERT:       invert_ff   <= csr_wdata[0];
            REG_USE_CONTROL:  use_ctl_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pin_level = rsp_level_ff;
   assign rsp_chan.pin_write = rsp_write_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gpg_div_unit.sv
// ----------------------------------------------------------------------------
// GPIO pattern generator divider
// Restoring divider, one quotient bit per cycle, that also reduces the
// quotient modulo the pattern length as its bits emerge.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_div_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  gpg_pkg::gpg_div_req_type           div_req,
   input  logic [gpg_pkg::PHASE_W-1:0]        divisor,
   input  logic [gpg_pkg::LEN_W-1:0]          pat_len,
   output gpg_pkg::gpg_div_rsp_type           div_rsp
);
   import gpg_pkg::*;

   logic [PHASE_W-1:0] rem_ff,  rem_in;
   logic [PHASE_W-1:0] dvd_ff,  dvd_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [IDX_W-1:0]   wm_ff,   wm_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [PHASE_W+1:0] diff;
   logic               qbit;
   logic [LEN_W-1:0]   wm_dbl;

   always_comb begin
      diff   = {1'b0, rem_ff, dvd_ff[PHASE_W-1]} - {2'b00, divisor};
      qbit   = ~diff[PHASE_W+1];
      // The running quotient modulo the length doubles and takes in the new bit.
      wm_dbl = {wm_ff, qbit};

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      wm_in   = wm_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         cnt_in  = '0;
         wm_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[PHASE_W-1:0] : {rem_ff[PHASE_W-2:0], dvd_ff[PHASE_W-1]};
         dvd_in = {dvd_ff[PHASE_W-2:0], 1'b0};
         wm_in  = (wm_dbl >= pat_len) ? IDX_W'(wm_dbl - pat_len) : wm_dbl[IDX_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PHASE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
      wm_ff  <= wm_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;
   assign div_rsp.wrap_mod  = wm_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gpg_checker.sv
// ----------------------------------------------------------------------------
// GPIO pattern generator checker
// Port-level assertions on the generator, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_checker (
   input  logic                               clock,
   input  logic                               reset,
   gpg_req_if.sink                            req_chan,
   gpg_rsp_if.source                          rsp_chan
);
   import gpg_pkg::*;

   // A stalled result word stays and keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.pin_level) && $stable(rsp_chan.pin_write))
      else $error("result word changed or dropped while stalled");

   // No tick is taken while an untaken result word would be overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |-> !(rsp_chan.valid && !rsp_chan.ready))
      else $error("tick accepted over a stalled result word");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result word present after reset");

endmodule

bind gpio_pattern_generator gpg_checker u_gpg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
